FILE: rtl/core/deq_pkg.sv
// Shared constants, opcodes and the command word passed from front to back.
package deq_pkg;

    // Store geometry
    localparam int DEPTH        = 1024;
    localparam int ADDR_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W      = $clog2(DEPTH + 1);
    localparam int SUM_W        = COUNT_W + 1;

    // Fixed field widths
    localparam int OPCODE_W     = 3;
    localparam int DATA_W       = 32;
    localparam int STATUS_W     = 2;
    localparam int ITEM_COUNT_W = 11;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_READ_FRONT = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_READ_BACK  = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_CLEAR      = 3'd6;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // One classified operation, ready for the store
    typedef struct packed {
        logic                           wr;
        logic                           rd;
        logic [ADDR_W-1:0]              addr;
        logic signed [DATA_W-1:0]       wdata;
        logic [STATUS_W-1:0]            status;
        logic [ITEM_COUNT_W-1:0]        count;
    } deq_cmd_t;

endpackage

FILE: rtl/core/double_ended_queue.sv
// Top level of the double-ended queue of signed 32-bit words.
// Double-ended queue holding up to 1024 signed 32-bit words in a circular store.
// Each input word carries an opcode (push front/back, pop front/back, read
// front/back, clear) and, for pushes, a value; each produces exactly one result
// word with the value read, a status (ok, empty, full) and the count after the
// operation. A push when full is refused with status full; a pop or read when
// empty leaves the queue unchanged with status empty. The front end updates the
// head and count and accepts one word per cycle while the command queue has
// room; the single-port store and the result register behind that two-entry
// queue take one operation per cycle while results are taken. A word passes a
// queue slot, then the result register. No clearing pass is needed after reset.
module double_ended_queue (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [deq_pkg::OPCODE_W-1:0]            opcode,
    input  logic signed [deq_pkg::DATA_W-1:0]       push_value,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [deq_pkg::DATA_W-1:0]       read_value,
    output logic [deq_pkg::STATUS_W-1:0]            status,
    output logic [deq_pkg::ITEM_COUNT_W-1:0]        item_count
);
    import deq_pkg::*;

    deq_cmd_t  front_cmd, back_cmd;
    logic      front_valid, front_ready;
    logic      back_valid, back_ready;

    deq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .push_value (push_value),
        .cmd_valid  (front_valid),
        .cmd_ready  (front_ready),
        .cmd        (front_cmd)
    );

    deq_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_cmd   (front_cmd),
        .rd_valid (back_valid),
        .rd_ready (back_ready),
        .rd_cmd   (back_cmd)
    );

    deq_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (back_valid),
        .cmd_ready  (back_ready),
        .cmd        (back_cmd),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_value (read_value),
        .status     (status),
        .item_count (item_count)
    );

endmodule

FILE: rtl/core/deq_front.sv
// Front end: accepts words, tracks head and count, emits store commands.
module deq_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [deq_pkg::OPCODE_W-1:0]        opcode,
    input  logic signed [deq_pkg::DATA_W-1:0]   push_value,
    output logic                                cmd_valid,
    input  logic                                cmd_ready,
    output deq_pkg::deq_cmd_t                   cmd
);
    import deq_pkg::*;

    logic [ADDR_W-1:0]  head_reg, head_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               full, empty, accept;
    logic [ADDR_W-1:0]  head_dec, head_inc, tail_addr, back_addr;
    logic [SUM_W-1:0]   back_sum, tail_sum;

    assign in_ready  = cmd_ready;
    assign cmd_valid = in_valid;
    assign accept    = in_valid && cmd_ready;

    assign full  = (count_reg == COUNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    // Neighbors of the head, wrapped around the store
    assign head_dec = (head_reg == '0) ? ADDR_W'(DEPTH - 1) : head_reg - ADDR_W'(1);
    assign head_inc = (head_reg == ADDR_W'(DEPTH - 1)) ? '0 : head_reg + ADDR_W'(1);

    // Slot past the last word, and the last word itself
    always_comb
    begin
        back_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
        tail_sum = back_sum - SUM_W'(1);
        if (back_sum >= SUM_W'(DEPTH))
            back_addr = ADDR_W'(back_sum - SUM_W'(DEPTH));
        else
            back_addr = ADDR_W'(back_sum);
        if (tail_sum >= SUM_W'(DEPTH))
            tail_addr = ADDR_W'(tail_sum - SUM_W'(DEPTH));
        else
            tail_addr = ADDR_W'(tail_sum);
    end

    // Classify the word and work out the new head and count
    always_comb
    begin
        head_next    = head_reg;
        count_next   = count_reg;
        cmd.wr       = 1'b0;
        cmd.rd       = 1'b0;
        cmd.addr     = head_reg;
        cmd.wdata    = push_value;
        cmd.status   = ST_OK;
        unique case (opcode)
            OP_PUSH_FRONT:
            begin
                if (full)
                    cmd.status = ST_FULL;
                else
                begin
                    cmd.wr     = 1'b1;
                    cmd.addr   = head_dec;
                    head_next  = head_dec;
                    count_next = count_reg + COUNT_W'(1);
                end
            end
            OP_PUSH_BACK:
            begin
                if (full)
                    cmd.status = ST_FULL;
                else
                begin
                    cmd.wr     = 1'b1;
                    cmd.addr   = back_addr;
                    count_next = count_reg + COUNT_W'(1);
                end
            end
            OP_POP_FRONT:
            begin
                if (empty)
                    cmd.status = ST_EMPTY;
                else
                begin
                    cmd.rd     = 1'b1;
                    head_next  = head_inc;
                    count_next = count_reg - COUNT_W'(1);
                end
            end
            OP_POP_BACK:
            begin
                if (empty)
                    cmd.status = ST_EMPTY;
                else
                begin
                    cmd.rd     = 1'b1;
                    cmd.addr   = tail_addr;
                    count_next = count_reg - COUNT_W'(1);
                end
            end
            OP_READ_FRONT:
            begin
                if (empty)
                    cmd.status = ST_EMPTY;
                else
                    cmd.rd = 1'b1;
            end
            OP_READ_BACK:
            begin
                if (empty)
                    cmd.status = ST_EMPTY;
                else
                begin
                    cmd.rd   = 1'b1;
                    cmd.addr = tail_addr;
                end
            end
            OP_CLEAR:
            begin
                head_next  = '0;
                count_next = '0;
            end
            default:
            begin
                // unused opcode: no operation
            end
        endcase
        cmd.count = ITEM_COUNT_W'(count_next);
    end

    // Advance pointer state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

endmodule

FILE: rtl/core/deq_cmd_queue.sv
// Two-entry command queue between the front end and the store.
module deq_cmd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_valid,
    output logic                wr_ready,
    input  deq_pkg::deq_cmd_t   wr_cmd,
    output logic                rd_valid,
    input  logic                rd_ready,
    output deq_pkg::deq_cmd_t   rd_cmd
);
    import deq_pkg::*;

    deq_cmd_t    slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;
    logic        do_wr, do_rd;

    assign wr_ready = (fill_reg != 2'd2);
    assign rd_valid = (fill_reg != 2'd0);
    assign rd_cmd   = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // Move pointers and fill level
    always_comb
    begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_wr && !do_rd)
            fill_next = fill_reg + 2'd1;
        else if (do_rd && !do_wr)
            fill_next = fill_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Hold queued commands
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_cmd;
    end

endmodule

FILE: rtl/core/deq_back.sv
// Back end: word store access and the registered result stage.
module deq_back (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cmd_valid,
    output logic                                    cmd_ready,
    input  deq_pkg::deq_cmd_t                       cmd,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [deq_pkg::DATA_W-1:0]       read_value,
    output logic [deq_pkg::STATUS_W-1:0]            status,
    output logic [deq_pkg::ITEM_COUNT_W-1:0]        item_count
);
    import deq_pkg::*;

    logic signed [DATA_W-1:0]  word_store [DEPTH];
    logic signed [DATA_W-1:0]  rdata_reg;
    logic                      valid_reg, valid_next;
    logic                      rd_reg;
    logic [STATUS_W-1:0]       status_reg;
    logic [ITEM_COUNT_W-1:0]   count_reg;
    logic                      advance, issue;

    // Result stage moves when empty or when its word is taken
    assign advance   = !valid_reg || out_ready;
    assign cmd_ready = advance;
    assign issue     = cmd_valid && advance;
    assign valid_next = advance ? cmd_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Capture result fields
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_reg     <= cmd.rd;
            status_reg <= cmd.status;
            count_reg  <= cmd.count;
        end
    end

    // Store write and registered read
    always_ff @(posedge clk)
    begin
        if (issue && cmd.wr)
            word_store[cmd.addr] <= cmd.wdata;
        if (issue && cmd.rd)
            rdata_reg <= word_store[cmd.addr];
    end

    assign out_valid  = valid_reg;
    assign read_value = rd_reg ? rdata_reg : '0;
    assign status     = status_reg;
    assign item_count = count_reg;

endmodule

FILE: verif/testbench.sv
// Testbench for the double-ended queue: directed, fill-to-full and random traffic.
module testbench;
    import deq_pkg::*;

    // Opcode 7 has no name in the package; it must act as a no-op
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;

    // One reply word as the block returns it
    typedef struct packed {
        logic signed [DATA_W-1:0]   value;
        logic [STATUS_W-1:0]        status;
        logic [ITEM_COUNT_W-1:0]    count;
    } deq_reply_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic [OPCODE_W-1:0]            opcode = OP_UNUSED;
    logic signed [DATA_W-1:0]       push_value = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic signed [DATA_W-1:0]       read_value;
    logic [STATUS_W-1:0]            status;
    logic [ITEM_COUNT_W-1:0]        item_count;

    // Shadow copy of the queue contents
    logic signed [DATA_W-1:0]       shadow_words [DEPTH];
    int                             shadow_head = 0;
    int                             shadow_count = 0;

    deq_reply_t                     replies_due [$];
    int                             send_idle_pct = 0;
    int                             recv_idle_pct = 0;
    int                             mismatch_count = 0;

    double_ended_queue dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .push_value (push_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_value (read_value),
        .status     (status),
        .item_count (item_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    // Apply one operation to the shadow queue and return the reply it owes
    function automatic deq_reply_t deque_op(input logic [OPCODE_W-1:0] op,
                                            input logic signed [DATA_W-1:0] val);
        deq_reply_t r;
        int         pos;
        r.value  = '0;
        r.status = ST_OK;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (shadow_count >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    if (op == OP_PUSH_FRONT)
                    begin
                        shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                        pos = shadow_head;
                    end
                    else
                        pos = (shadow_head + shadow_count) % DEPTH;
                    shadow_words[pos] = val;
                    shadow_count++;
                end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_READ_FRONT, OP_READ_BACK:
            begin
                if (shadow_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    if (op == OP_POP_FRONT || op == OP_READ_FRONT)
                        pos = shadow_head;
                    else
                        pos = (shadow_head + shadow_count - 1) % DEPTH;
                    r.value = shadow_words[pos];
                    if (op == OP_POP_FRONT)
                    begin
                        shadow_head = (shadow_head + 1) % DEPTH;
                        shadow_count--;
                    end
                    else if (op == OP_POP_BACK)
                        shadow_count--;
                end
            end
            OP_CLEAR:
            begin
                shadow_head  = 0;
                shadow_count = 0;
            end
            default:
            begin
            end
        endcase
        r.count = shadow_count[ITEM_COUNT_W-1:0];
        return r;
    endfunction

    // Random word, with the extremes mixed in now and then
    function automatic logic signed [DATA_W-1:0] pick_word();
        case ($urandom_range(9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return -32'sd1;
            3:       return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    // Print one mismatch line (capped) and count it
    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("mismatch %s: got 0x%h, want 0x%h at %0t", what, got, want, $time);
    endtask

    // Offer one word, hold it until accepted, then record the reply it owes
    task automatic send_word(input logic [OPCODE_W-1:0] op,
                             input logic signed [DATA_W-1:0] val);
        deq_reply_t want;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        push_value <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        want = deque_op(op, val);
        replies_due.insert(replies_due.size(), want);
    endtask

    // Stall the result side at random
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Check each accepted reply against the oldest one owed
    always @(posedge clk)
    begin
        deq_reply_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (replies_due.size() == 0)
                report_mismatch("reply with none owed", read_value, '0);
            else
            begin
                want = replies_due[0];
                replies_due.delete(0);
                if (read_value !== want.value)
                    report_mismatch("read_value", read_value, want.value);
                if (status !== want.status)
                    report_mismatch("status", DATA_W'(status), DATA_W'(want.status));
                if (item_count !== want.count)
                    report_mismatch("item_count", DATA_W'(item_count), DATA_W'(want.count));
            end
        end
    end

    // Empty errors, every opcode, head wrap below zero, extremes, clear
    task automatic test_directed();
        send_word(OP_POP_FRONT, 32'sd0);
        send_word(OP_POP_BACK, 32'sd0);
        send_word(OP_READ_FRONT, 32'sd0);
        send_word(OP_READ_BACK, 32'sd0);
        send_word(OP_UNUSED, -32'sd1);
        send_word(OP_PUSH_FRONT, 32'sh7fff_ffff);
        send_word(OP_PUSH_BACK, 32'sh8000_0000);
        send_word(OP_PUSH_FRONT, -32'sd1);
        send_word(OP_PUSH_BACK, 32'sd0);
        send_word(OP_READ_FRONT, 32'sh5555_5555);
        send_word(OP_READ_BACK, 32'shaaaa_aaaa);
        send_word(OP_UNUSED, 32'sh1234_5678);
        send_word(OP_POP_BACK, 32'sd0);
        send_word(OP_POP_FRONT, 32'sd0);
        send_word(OP_READ_FRONT, 32'sd0);
        send_word(OP_READ_BACK, 32'sd0);
        send_word(OP_POP_FRONT, 32'sd0);
        send_word(OP_POP_BACK, 32'sd0);
        send_word(OP_POP_FRONT, 32'sd0);
        send_word(OP_PUSH_BACK, 32'sd123);
        send_word(OP_PUSH_FRONT, 32'sd456);
        send_word(OP_CLEAR, 32'sd789);
        send_word(OP_READ_FRONT, 32'sd0);
        send_word(OP_PUSH_FRONT, -32'sd2);
        send_word(OP_POP_BACK, 32'sd0);
    endtask

    // Fill to capacity, hit the full error at both ends, refill, clear
    task automatic test_full();
        int k;
        send_word(OP_CLEAR, 32'sd0);
        while (shadow_count < DEPTH)
            send_word($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_word());
        send_word(OP_PUSH_FRONT, pick_word());
        send_word(OP_PUSH_BACK, pick_word());
        send_word(OP_UNUSED, pick_word());
        send_word(OP_READ_FRONT, 32'sd0);
        send_word(OP_READ_BACK, 32'sd0);
        for (k = 0; k < 8; k++)
            send_word($urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK, 32'sd0);
        while (shadow_count < DEPTH)
            send_word($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_word());
        send_word(OP_PUSH_BACK, pick_word());
        send_word(OP_CLEAR, 32'sd0);
        send_word(OP_POP_BACK, 32'sd0);
    endtask

    // Mixed traffic; the push bias keeps the fill level wandering
    task automatic test_random(input int n);
        int                     k;
        int                     r;
        int                     push_pct;
        logic [OPCODE_W-1:0]    op;
        for (k = 0; k < n; k++)
        begin
            r = $urandom_range(99);
            push_pct = (shadow_count < 4) ? 70 : (shadow_count > 48) ? 30 : 52;
            if (r < 1)
                op = OP_CLEAR;
            else if (r < 2)
                op = OP_UNUSED;
            else if ($urandom_range(99) < push_pct)
                op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
            else
                case ($urandom_range(3))
                    0:       op = OP_POP_FRONT;
                    1:       op = OP_POP_BACK;
                    2:       op = OP_READ_FRONT;
                    default: op = OP_READ_BACK;
                endcase
            send_word(op, pick_word());
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Sender mostly busy, receiver stalling a lot
        send_idle_pct = 16;
        recv_idle_pct = 81;
        test_directed();
        test_full();
        test_random(140);

        // Sender idling a lot, receiver mostly ready
        send_idle_pct = 81;
        recv_idle_pct = 16;
        test_random(140);

        // Full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(140);

        // Drain, then keep watching for any stray reply
        in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/deq_pkg.sv
rtl/core/deq_front.sv
rtl/core/deq_cmd_queue.sv
rtl/core/deq_back.sv
rtl/core/double_ended_queue.sv
verif/testbench.sv
